[design/bqred_pkg.sv]
// Package for the byte queue with random early drop.
// Field widths, reset values, command codes and CSR indexes.
// No dependencies.
package bqred_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;

   localparam int BYTES_W     = 24;
   localparam int SIZE_W      = 16;
   localparam int TAG_W       = 16;
   localparam int DRAW_W      = 16;
   localparam int TPB_W       = 20;
   localparam int SCHED_W     = 39;
   localparam int WAIT_W      = 47;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   // bytes to bits
   localparam int BYTE_SHIFT = 3;

   localparam int MUL_W  = 24;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 24'd65536;
   localparam logic [BYTES_W-1:0] THRESHOLD_RESET = 24'd49152;
   localparam logic               RANDOM_EN_RESET = 1'b0;
   localparam logic [TPB_W-1:0]   TPB_RESET       = 20'd100;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_TX_DONE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_BYTES,
      CSR_THRESHOLD,
      CSR_RANDOM_EN,
      CSR_TIME_PER_BIT
   } csr_index_type;

endpackage

[design/bqred_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Depends on bqred_pkg for default sizes.
module bqred_ram #(
   parameter int WIDTH = bqred_pkg::SIZE_W + bqred_pkg::TAG_W,
   parameter int DEPTH = bqred_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/byte_queue_with_random_early_drop.sv]
// Packet descriptor queue with byte accounting and random early drop.
// Depends on bqred_pkg and bqred_ram.
//
// Usage:
//   Commands enter on start/req_* and are taken when start is high and busy
//   is low. req_command selects an arrival or a transmit-done event.
//   Every command gives exactly one result beat, shown on rsp_* for one
//   cycle with rsp_strobe high. The receiver cannot stall; no beat waits.
//   States from the accepting edge to the result beat:
//     transmit-done, queue empty        answered from idle
//     transmit-done, last packet        pop
//     transmit-done, more packets       pop, read, load, multiply, done
//     arrival dropped                   span, decide
//     arrival admitted                  span, decide, wait, drain, done
//   busy drops in the cycle of the result beat, so the next command can be
//   taken then; no command is taken while one is in progress. The paths
//   follow from one shared 24x24 multiplier (drop test, wait estimate,
//   drain time) with a registered product, and the registered descriptor
//   RAM read. The user must make csr_* writes only while the block is idle;
//   the block itself does not enforce this. Reset clears the queue and loads
//   the register defaults; the descriptor RAM is not cleared.
module byte_queue_with_random_early_drop #(
   parameter int QUEUE_DEPTH = bqred_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_command,
   input  logic [bqred_pkg::SIZE_W-1:0]           req_packet_size,
   input  logic [bqred_pkg::TAG_W-1:0]            req_packet_tag,
   input  logic [bqred_pkg::DRAW_W-1:0]           req_random_draw,
   output logic                                   rsp_strobe,
   output logic                                   rsp_dropped,
   output logic                                   rsp_departed_valid,
   output logic [bqred_pkg::TAG_W-1:0]            rsp_departed_tag,
   output logic [bqred_pkg::SIZE_W-1:0]           rsp_departed_size,
   output logic                                   rsp_schedule_valid,
   output logic [bqred_pkg::SCHED_W-1:0]          rsp_schedule_delay_ps,
   output logic [bqred_pkg::WAIT_W-1:0]           rsp_wait_estimate_ps,
   output logic [bqred_pkg::BYTES_W-1:0]          rsp_occupancy_bytes,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_occupancy_packets,
   input  logic                                   csr_write_enable,
   input  bqred_pkg::csr_index_type               csr_index,
   input  logic [bqred_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import bqred_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = SIZE_W + TAG_W;
   localparam int TOTAL_W = BYTES_W + 1;

   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARR_SPAN,
      ST_ARR_DECIDE,
      ST_ARR_WAIT_MUL,
      ST_ARR_DRAIN_MUL,
      ST_ARR_DONE,
      ST_DEP_POP,
      ST_DEP_READ,
      ST_DEP_LOAD,
      ST_DEP_MUL,
      ST_DEP_DONE
   } state_type;

   state_type state_ff;

   logic [BYTES_W-1:0] max_bytes_ff;
   logic [BYTES_W-1:0] threshold_ff;
   logic               random_en_ff;
   logic [TPB_W-1:0]   tpb_ff;

   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   tail_ff;
   logic [BYTES_W-1:0] byte_count_ff;
   logic [CNT_W-1:0]   packet_count_ff;

   logic [SIZE_W-1:0]  size_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] above_ff;
   logic               full_ff;
   logic               over_ff;
   logic               gt_thr_ff;
   logic               was_empty_ff;

   logic [MUL_W-1:0]   mul_a_ff;
   logic [MUL_W-1:0]   mul_b_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic [PTR_W-1:0]   head_in;
   logic [PTR_W-1:0]   tail_in;
   logic [BYTES_W-1:0] byte_left_in;
   logic               random_drop_in;
   logic               drop_in;
   logic               ram_wr_en_in;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [SIZE_W-1:0]  rd_size;
   logic [TAG_W-1:0]   rd_tag;
   logic [BYTES_W-1:0] rd_size_ext;

   assign busy = (state_ff != ST_IDLE);

   assign rd_size     = ram_rd_data[ENTRY_W-1:TAG_W];
   assign rd_tag      = ram_rd_data[TAG_W-1:0];
   assign rd_size_ext = BYTES_W'(rd_size);

   assign head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   assign byte_left_in = (byte_count_ff >= rd_size_ext) ? byte_count_ff - rd_size_ext : '0;

   // draw * span < above * 65536
   assign random_drop_in = random_en_ff && gt_thr_ff &&
                           (prod_ff < PROD_W'({above_ff, {DRAW_W{1'b0}}}));
   assign drop_in        = over_ff || full_ff || random_drop_in;
   assign ram_wr_en_in   = (state_ff == ST_ARR_DECIDE) && !drop_in;

   assign rsp_occupancy_bytes   = byte_count_ff;
   assign rsp_occupancy_packets = packet_count_ff;

   bqred_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en_in),
      .wr_addr (tail_ff),
      .wr_data ({size_ff, tag_ff}),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
         threshold_ff <= THRESHOLD_RESET;
         random_en_ff <= RANDOM_EN_RESET;
         tpb_ff       <= TPB_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_BYTES:    max_bytes_ff <= csr_write_data[BYTES_W-1:0];
            CSR_THRESHOLD:    threshold_ff <= csr_write_data[BYTES_W-1:0];
            CSR_RANDOM_EN:    random_en_ff <= csr_write_data[0];
            CSR_TIME_PER_BIT: tpb_ff       <= csr_write_data[TPB_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier, registered product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a_ff * mul_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_strobe      <= 1'b0;
         head_ff         <= '0;
         tail_ff         <= '0;
         byte_count_ff   <= '0;
         packet_count_ff <= '0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  size_ff <= req_packet_size;
                  tag_ff  <= req_packet_tag;
                  if (req_command == CMD_ARRIVAL) begin
                     mul_a_ff <= MUL_W'(req_random_draw);
                     mul_b_ff <= max_bytes_ff - threshold_ff;
                     total_ff <= TOTAL_W'(byte_count_ff) + TOTAL_W'(req_packet_size);
                     full_ff  <= (packet_count_ff == FULL_COUNT);
                     state_ff <= ST_ARR_SPAN;
                  end else if (packet_count_ff == '0) begin
                     rsp_strobe            <= 1'b1;
                     rsp_dropped           <= 1'b0;
                     rsp_departed_valid    <= 1'b0;
                     rsp_departed_tag      <= '0;
                     rsp_departed_size     <= '0;
                     rsp_schedule_valid    <= 1'b0;
                     rsp_schedule_delay_ps <= '0;
                     rsp_wait_estimate_ps  <= '0;
                  end else begin
                     state_ff <= ST_DEP_POP;
                  end
               end
            end
            ST_ARR_SPAN: begin
               over_ff   <= (total_ff > TOTAL_W'(max_bytes_ff));
               gt_thr_ff <= (total_ff > TOTAL_W'(threshold_ff));
               above_ff  <= total_ff - TOTAL_W'(threshold_ff);
               state_ff  <= ST_ARR_DECIDE;
            end
            ST_ARR_DECIDE: begin
               if (drop_in) begin
                  rsp_strobe            <= 1'b1;
                  rsp_dropped           <= 1'b1;
                  rsp_departed_valid    <= 1'b0;
                  rsp_departed_tag      <= '0;
                  rsp_departed_size     <= '0;
                  rsp_schedule_valid    <= 1'b0;
                  rsp_schedule_delay_ps <= '0;
                  rsp_wait_estimate_ps  <= '0;
                  state_ff              <= ST_IDLE;
               end else begin
                  mul_a_ff        <= byte_count_ff;
                  mul_b_ff        <= MUL_W'(tpb_ff);
                  was_empty_ff    <= (packet_count_ff == '0);
                  tail_ff         <= tail_in;
                  byte_count_ff   <= total_ff[BYTES_W-1:0];
                  packet_count_ff <= packet_count_ff + 1'b1;
                  state_ff        <= ST_ARR_WAIT_MUL;
               end
            end
            ST_ARR_WAIT_MUL: begin
               mul_a_ff <= MUL_W'(size_ff);
               state_ff <= ST_ARR_DRAIN_MUL;
            end
            ST_ARR_DRAIN_MUL: begin
               rsp_wait_estimate_ps <= {prod_ff[BYTES_W+TPB_W-1:0], {BYTE_SHIFT{1'b0}}};
               state_ff             <= ST_ARR_DONE;
            end
            ST_ARR_DONE: begin
               rsp_strobe         <= 1'b1;
               rsp_dropped        <= 1'b0;
               rsp_departed_valid <= 1'b0;
               rsp_departed_tag   <= '0;
               rsp_departed_size  <= '0;
               rsp_schedule_valid <= was_empty_ff;
               rsp_schedule_delay_ps <= was_empty_ff ?
                  {prod_ff[SIZE_W+TPB_W-1:0], {BYTE_SHIFT{1'b0}}} : '0;
               state_ff           <= ST_IDLE;
            end
            ST_DEP_POP: begin
               rsp_departed_tag   <= rd_tag;
               rsp_departed_size  <= rd_size;
               head_ff            <= head_in;
               byte_count_ff      <= byte_left_in;
               packet_count_ff    <= packet_count_ff - 1'b1;
               if (packet_count_ff == ONE_COUNT) begin
                  rsp_strobe            <= 1'b1;
                  rsp_dropped           <= 1'b0;
                  rsp_departed_valid    <= 1'b1;
                  rsp_schedule_valid    <= 1'b0;
                  rsp_schedule_delay_ps <= '0;
                  rsp_wait_estimate_ps  <= '0;
                  state_ff              <= ST_IDLE;
               end else begin
                  state_ff <= ST_DEP_READ;
               end
            end
            ST_DEP_READ: begin
               // RAM read of the new head is in flight
               state_ff <= ST_DEP_LOAD;
            end
            ST_DEP_LOAD: begin
               mul_a_ff <= MUL_W'(rd_size);
               mul_b_ff <= MUL_W'(tpb_ff);
               state_ff <= ST_DEP_MUL;
            end
            ST_DEP_MUL: begin
               state_ff <= ST_DEP_DONE;
            end
            ST_DEP_DONE: begin
               rsp_strobe            <= 1'b1;
               rsp_dropped           <= 1'b0;
               rsp_departed_valid    <= 1'b1;
               rsp_schedule_valid    <= 1'b1;
               rsp_schedule_delay_ps <= {prod_ff[SIZE_W+TPB_W-1:0], {BYTE_SHIFT{1'b0}}};
               rsp_wait_estimate_ps  <= '0;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (packet_count_ff == '0) |-> (byte_count_ff == '0))
      else $error("bytes held with no packets");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_occupancy_packets <= FULL_COUNT))
      else $error("packet count above depth");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_dropped) |->
         (!rsp_departed_valid && !rsp_schedule_valid && (rsp_wait_estimate_ps == '0)))
      else $error("dropped beat carries other results");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command neither in progress nor answered");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en_in |-> (packet_count_ff != FULL_COUNT))
      else $error("push into full queue");

endmodule

[sim/bqred_checker.sv]
// Checker for the byte queue with random early drop: watches the command,
// result and CSR ports, predicts each result beat and compares it field by field.
// Depends on bqred_pkg.
module bqred_checker #(
   parameter int QUEUE_DEPTH = bqred_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic                                   req_command,
   input  logic [bqred_pkg::SIZE_W-1:0]           req_packet_size,
   input  logic [bqred_pkg::TAG_W-1:0]            req_packet_tag,
   input  logic [bqred_pkg::DRAW_W-1:0]           req_random_draw,
   input  logic                                   rsp_strobe,
   input  logic                                   rsp_dropped,
   input  logic                                   rsp_departed_valid,
   input  logic [bqred_pkg::TAG_W-1:0]            rsp_departed_tag,
   input  logic [bqred_pkg::SIZE_W-1:0]           rsp_departed_size,
   input  logic                                   rsp_schedule_valid,
   input  logic [bqred_pkg::SCHED_W-1:0]          rsp_schedule_delay_ps,
   input  logic [bqred_pkg::WAIT_W-1:0]           rsp_wait_estimate_ps,
   input  logic [bqred_pkg::BYTES_W-1:0]          rsp_occupancy_bytes,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_occupancy_packets,
   input  logic                                   csr_write_enable,
   input  bqred_pkg::csr_index_type               csr_index,
   input  logic [bqred_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output int                                     pending,
   output int                                     failure_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import bqred_pkg::*;

   localparam int PKT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                 dropped;
      logic                 departed_valid;
      logic [TAG_W-1:0]     departed_tag;
      logic [SIZE_W-1:0]    departed_size;
      logic                 schedule_valid;
      logic [SCHED_W-1:0]   schedule_delay_ps;
      logic [WAIT_W-1:0]    wait_estimate_ps;
      logic [BYTES_W-1:0]   occupancy_bytes;
      logic [PKT_W-1:0]     occupancy_packets;
   } queue_report_type;

   queue_report_type reports_due[$];
   queue_report_type want;
   queue_report_type got;
   queue_report_type fresh;

   logic [SIZE_W-1:0]  size_mem [QUEUE_DEPTH];
   logic [TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
   int unsigned        head_slot;
   int unsigned        tail_slot;
   int unsigned        held_packets;
   logic [BYTES_W-1:0] held_bytes;

   logic [BYTES_W-1:0] limit_bytes;
   logic [BYTES_W-1:0] red_threshold;
   logic               red_enable;
   logic [TPB_W-1:0]   ps_per_bit;

   function automatic logic [63:0] line_time_ps(input logic [63:0] bytes);
      return (bytes << BYTE_SHIFT) * 64'(ps_per_bit);
   endfunction

   function automatic logic refused(input logic [SIZE_W-1:0] size,
                                    input logic [DRAW_W-1:0] draw);
      logic [63:0] total;
      logic [63:0] span;
      logic [63:0] above;
      total = 64'(held_bytes) + 64'(size);
      if (total > 64'(limit_bytes)) return 1'b1;
      if (held_packets >= QUEUE_DEPTH) return 1'b1;
      if (red_enable && total > 64'(red_threshold)) begin
         span  = 64'(limit_bytes) - 64'(red_threshold);
         above = total - 64'(red_threshold);
         if (64'(draw) * span < (above << DRAW_W)) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic apply_event(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [TAG_W-1:0] tag,
                              input logic [DRAW_W-1:0] draw,
                              output queue_report_type r);
      logic [SIZE_W-1:0] gone;
      r = '0;
      if (cmd == CMD_ARRIVAL) begin
         if (refused(size, draw)) begin
            r.dropped = 1'b1;
         end else begin
            r.wait_estimate_ps = WAIT_W'(line_time_ps(64'(held_bytes)));
            if (held_packets == 0) begin
               r.schedule_valid    = 1'b1;
               r.schedule_delay_ps = SCHED_W'(line_time_ps(64'(size)));
            end
            size_mem[tail_slot] = size;
            tag_mem[tail_slot]  = tag;
            tail_slot    = (tail_slot + 1) % QUEUE_DEPTH;
            held_bytes   = held_bytes + BYTES_W'(size);
            held_packets = held_packets + 1;
         end
      end else if (held_packets != 0) begin
         gone = size_mem[head_slot];
         r.departed_valid = 1'b1;
         r.departed_tag   = tag_mem[head_slot];
         r.departed_size  = gone;
         head_slot    = (head_slot + 1) % QUEUE_DEPTH;
         held_bytes   = (held_bytes >= BYTES_W'(gone)) ? held_bytes - BYTES_W'(gone) : '0;
         held_packets = held_packets - 1;
         if (held_packets != 0) begin
            r.schedule_valid    = 1'b1;
            r.schedule_delay_ps = SCHED_W'(line_time_ps(64'(size_mem[head_slot])));
         end
      end
      r.occupancy_bytes   = held_bytes;
      r.occupancy_packets = PKT_W'(held_packets);
   endtask

   task automatic check_field(input string label, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, label, exp_v, act_v);
         failure_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reports_due.delete();
         head_slot     = 0;
         tail_slot     = 0;
         held_packets  = 0;
         held_bytes    = '0;
         limit_bytes   = MAX_BYTES_RESET;
         red_threshold = THRESHOLD_RESET;
         red_enable    = RANDOM_EN_RESET;
         ps_per_bit    = TPB_RESET;
         failure_count = 0;
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            got = {rsp_dropped, rsp_departed_valid, rsp_departed_tag, rsp_departed_size,
                   rsp_schedule_valid, rsp_schedule_delay_ps, rsp_wait_estimate_ps,
                   rsp_occupancy_bytes, rsp_occupancy_packets};
            if (reports_due.size() == 0) begin
               $display("%0t: result beat with no command outstanding", $time);
               failure_count++;
            end else begin
               want = reports_due[0];
               reports_due.delete(0);
               check_field("dropped", 64'(want.dropped), 64'(got.dropped));
               check_field("departed_valid", 64'(want.departed_valid),
                           64'(got.departed_valid));
               check_field("departed_tag", 64'(want.departed_tag), 64'(got.departed_tag));
               check_field("departed_size", 64'(want.departed_size),
                           64'(got.departed_size));
               check_field("schedule_valid", 64'(want.schedule_valid),
                           64'(got.schedule_valid));
               check_field("schedule_delay_ps", 64'(want.schedule_delay_ps),
                           64'(got.schedule_delay_ps));
               check_field("wait_estimate_ps", 64'(want.wait_estimate_ps),
                           64'(got.wait_estimate_ps));
               check_field("occupancy_bytes", 64'(want.occupancy_bytes),
                           64'(got.occupancy_bytes));
               check_field("occupancy_packets", 64'(want.occupancy_packets),
                           64'(got.occupancy_packets));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_BYTES:    limit_bytes   = csr_write_data[BYTES_W-1:0];
               CSR_THRESHOLD:    red_threshold = csr_write_data[BYTES_W-1:0];
               CSR_RANDOM_EN:    red_enable    = csr_write_data[0];
               CSR_TIME_PER_BIT: ps_per_bit    = csr_write_data[TPB_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            apply_event(req_command, req_packet_size, req_packet_tag, req_random_draw,
                        fresh);
            reports_due = {reports_due, fresh};
         end
         pending <= reports_due.size();
      end
   end

endmodule

[sim/byte_queue_with_random_early_drop_tb.sv]
// Testbench top for byte_queue_with_random_early_drop: clock, reset, command
// and CSR stimulus, verdict. Checking lives in bqred_checker.
// Depends on bqred_pkg, bqred_checker and the block's RTL.
module byte_queue_with_random_early_drop_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bqred_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 128;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_command = CMD_ARRIVAL;
   logic [SIZE_W-1:0]        req_packet_size = '0;
   logic [TAG_W-1:0]         req_packet_tag = '0;
   logic [DRAW_W-1:0]        req_random_draw = '0;
   logic                     rsp_strobe;
   logic                     rsp_dropped;
   logic                     rsp_departed_valid;
   logic [TAG_W-1:0]         rsp_departed_tag;
   logic [SIZE_W-1:0]        rsp_departed_size;
   logic                     rsp_schedule_valid;
   logic [SCHED_W-1:0]       rsp_schedule_delay_ps;
   logic [WAIT_W-1:0]        rsp_wait_estimate_ps;
   logic [BYTES_W-1:0]       rsp_occupancy_bytes;
   logic [$clog2(DEPTH+1)-1:0] rsp_occupancy_packets;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index = CSR_MAX_BYTES;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;
   int                       pending;
   int                       failure_count;
   int                       cycle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   byte_queue_with_random_early_drop #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_packet_size(req_packet_size),
      .req_packet_tag(req_packet_tag), .req_random_draw(req_random_draw),
      .rsp_strobe(rsp_strobe), .rsp_dropped(rsp_dropped),
      .rsp_departed_valid(rsp_departed_valid), .rsp_departed_tag(rsp_departed_tag),
      .rsp_departed_size(rsp_departed_size), .rsp_schedule_valid(rsp_schedule_valid),
      .rsp_schedule_delay_ps(rsp_schedule_delay_ps),
      .rsp_wait_estimate_ps(rsp_wait_estimate_ps),
      .rsp_occupancy_bytes(rsp_occupancy_bytes),
      .rsp_occupancy_packets(rsp_occupancy_packets),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   bqred_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_packet_size(req_packet_size),
      .req_packet_tag(req_packet_tag), .req_random_draw(req_random_draw),
      .rsp_strobe(rsp_strobe), .rsp_dropped(rsp_dropped),
      .rsp_departed_valid(rsp_departed_valid), .rsp_departed_tag(rsp_departed_tag),
      .rsp_departed_size(rsp_departed_size), .rsp_schedule_valid(rsp_schedule_valid),
      .rsp_schedule_delay_ps(rsp_schedule_delay_ps),
      .rsp_wait_estimate_ps(rsp_wait_estimate_ps),
      .rsp_occupancy_bytes(rsp_occupancy_bytes),
      .rsp_occupancy_packets(rsp_occupancy_packets),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .pending(pending), .failure_count(failure_count)
   );

   task automatic issue_event(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [TAG_W-1:0] tag,
                              input logic [DRAW_W-1:0] draw);
      start           <= 1'b1;
      req_command     <= cmd;
      req_packet_size <= size;
      req_packet_tag  <= tag;
      req_random_draw <= draw;
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_pause(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // every command gives one beat; the extra cycles cover the longest latency
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_registers(input logic [BYTES_W-1:0] byte_limit,
                                 input logic [BYTES_W-1:0] red_level,
                                 input logic red_on, input logic [TPB_W-1:0] tpb);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAX_BYTES;
      csr_write_data   <= CSR_DATA_W'(byte_limit);
      @(posedge clock);
      csr_index      <= CSR_THRESHOLD;
      csr_write_data <= CSR_DATA_W'(red_level);
      @(posedge clock);
      csr_index      <= CSR_RANDOM_EN;
      csr_write_data <= CSR_DATA_W'(red_on);
      @(posedge clock);
      csr_index      <= CSR_TIME_PER_BIT;
      csr_write_data <= CSR_DATA_W'(tpb);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_event(input int arrival_pct, input logic small_only);
      logic [SIZE_W-1:0] size;
      logic              cmd;
      int                pick;
      pick = small_only ? $urandom_range(4, 1) : $urandom_range(9);
      case (pick)
         0:       size = $urandom_range(1) ? '1 : '0;
         1, 2, 3, 4: size = SIZE_W'($urandom_range(255, 1));
         5, 6, 7: size = SIZE_W'($urandom_range(8191, 256));
         default: size = SIZE_W'($urandom);
      endcase
      cmd = ($urandom_range(99) < arrival_pct) ? CMD_ARRIVAL : CMD_TX_DONE;
      issue_event(cmd, size, TAG_W'($urandom), DRAW_W'($urandom));
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("byte_queue_with_random_early_drop_tb: errors");
      $finish;
   end

   initial begin
      int   arrival_pct;
      int   idle_pct;
      logic fill;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // tail drop at reset values: empty pop, zero-byte packet, exact byte limit
      issue_event(CMD_TX_DONE, '1, '1, '1);
      issue_event(CMD_ARRIVAL, 16'h0000, 16'h0000, 16'h0000);
      issue_event(CMD_ARRIVAL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      issue_event(CMD_ARRIVAL, 16'd2, 16'h1234, 16'h0000);
      issue_event(CMD_ARRIVAL, 16'd1, 16'h5A5A, 16'hA5A5);
      repeat (4) issue_event(CMD_TX_DONE, 16'h0000, 16'h0000, 16'h0000);
      wait_for_results();

      // early drop at the threshold edge and at the limit, slowest line rate
      load_registers(24'd65536, 24'd49152, 1'b1, '1);
      issue_event(CMD_ARRIVAL, 16'd49152, 16'h0001, 16'h0000);
      issue_event(CMD_ARRIVAL, 16'd1, 16'h0002, 16'h0000);
      issue_event(CMD_ARRIVAL, 16'd1, 16'h0003, 16'hFFFF);
      issue_event(CMD_ARRIVAL, 16'd16383, 16'h0004, 16'hFFFF);
      issue_event(CMD_ARRIVAL, 16'd16382, 16'h0005, 16'hFFFF);
      repeat (2) issue_event(CMD_TX_DONE, '1, '1, '1);

      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         fill = 1'b0;
         case (p)
            0: load_registers(24'd65536, 24'd49152, 1'b1, 20'd100);
            1: load_registers('1, 24'd0, 1'b1, '1);
            2: load_registers(24'd4000, 24'd1000, 1'b1, 20'd0);
            3: load_registers(24'd1, 24'd0, 1'b0, 20'd1);
            4: load_registers('1, 24'hFFFFFE, 1'b1, 20'd1000000);
            5: load_registers(24'd20000, 24'd30000, 1'b1, 20'd7);
            6: load_registers(24'd0, 24'd0, 1'b1, 20'd8);
            7: begin
               load_registers(24'd300000, 24'd100000, 1'b0, 20'd1000000);
               fill = 1'b1;
            end
            default: begin
               load_registers(24'd12000, 24'd2000, 1'b1, 20'd52);
               fill = 1'b1;
            end
         endcase
         idle_pct = (p < 3) ? 33 : (p < 6) ? 77 : 0;
         arrival_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 32 == 0) begin
               case ($urandom_range(2))
                  0:       arrival_pct = 25;
                  1:       arrival_pct = 50;
                  default: arrival_pct = 85;
               endcase
               if (fill) arrival_pct = 90;
            end
            random_event(arrival_pct, fill);
            sender_pause(idle_pct);
            if ($urandom_range(39) == 0) wait_for_results();
         end
      end

      wait_for_results();
      if (failure_count == 0) begin
         $display("byte_queue_with_random_early_drop_tb: clean");
      end else begin
         $display("byte_queue_with_random_early_drop_tb: errors");
      end
      $finish;
   end

endmodule

[byte_queue_with_random_early_drop.f]
design/bqred_pkg.sv
design/bqred_ram.sv
design/byte_queue_with_random_early_drop.sv
sim/bqred_checker.sv
sim/byte_queue_with_random_early_drop_tb.sv
